/* rtl/tsarq_pkg.sv */
`timescale 1ns / 1ps

package tsarq_pkg;

   localparam int TIME_W  = 64;
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 7;

   localparam int CAPACITY_DEFAULT = 64;

   // Stream payload widths: tdata fields packed from bit 0 and rounded up to bytes.
   localparam int REQ_TDATA_W = 256;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_FIELDS_W = 2 * TIME_W + WORD_W + TIME_W + 2 * COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 3;

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_APPENDED  = 2'd0;
   localparam logic [1:0] STATUS_NOT_NEWER = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_QUERY     = 2'd3;

   typedef logic signed [TIME_W-1:0] stamp_type;
   typedef logic [WORD_W-1:0]        word_type;

endpackage

/* rtl/time_series_append_range_query.sv */
`timescale 1ns / 1ps

// Append-only store of up to CAPACITY (timestamp, value word) pairs with an
// inclusive range query. An append yields one status transaction; it is refused when
// its timestamp is not strictly newer than the newest stored one (checked first) or
// when the store is full. A query scans the store from oldest to newest through a
// registered RAM read and one shared bounds comparator, in a read state and then a
// compare state per stored entry, so after a query is taken the request side is held
// off until the scan ends and its final result is registered, and longer while the
// response side stalls. Each match is sent as its own transaction, the final one with
// tlast; a query with no match gives one empty result. Every result carries the
// stored count and the oldest and newest timestamps (zero while empty).
module time_series_append_range_query
   #(
   parameter int CAPACITY = tsarq_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_time[63:0], point_word[127:64], range_start[191:128], range_end[255:192]
   input  logic [tsarq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action[0]
   input  logic [tsarq_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // entry_time[63:0], entry_word[127:64], match_count[134:128],
   // stored_count[141:135], first_time[205:142], newest_time[269:206], zeros
   output logic [tsarq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status[1:0], entry_found[2]
   output logic [tsarq_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   // last_of_run
   output logic                               rsp_tlast
);

   import tsarq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] scan_ff, scan_in;
   stamp_type     first_ff, first_in;
   stamp_type     newest_ff, newest_in;
   stamp_type     lo_ff, lo_in;
   stamp_type     hi_ff, hi_in;

   logic          pend_valid_ff, pend_valid_in;
   stamp_type     pend_time_ff, pend_time_in;
   word_type      pend_word_ff, pend_word_in;
   logic [CW-1:0] pend_count_ff, pend_count_in;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic          out_found_ff, out_found_in;
   stamp_type     out_time_ff, out_time_in;
   word_type      out_word_ff, out_word_in;
   logic          out_last_ff, out_last_in;
   logic [CW-1:0] out_count_ff, out_count_in;
   logic [CW-1:0] out_stored_ff, out_stored_in;
   stamp_type     out_first_ff, out_first_in;
   stamp_type     out_newest_ff, out_newest_in;

   logic          out_free;
   logic          req_accept;
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [TIME_W+WORD_W-1:0] ram_rd_data;
   stamp_type     rd_time;
   word_type      rd_word;
   logic          in_range;

   stamp_type     req_time;
   word_type      req_word;
   stamp_type     req_lo;
   stamp_type     req_hi;

   assign req_time = req_tdata[TIME_W-1:0];
   assign req_word = req_tdata[TIME_W+WORD_W-1:TIME_W];
   assign req_lo   = req_tdata[2*TIME_W+WORD_W-1:TIME_W+WORD_W];
   assign req_hi   = req_tdata[3*TIME_W+WORD_W-1:2*TIME_W+WORD_W];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;

   assign rd_time  = ram_rd_data[TIME_W-1:0];
   assign rd_word  = ram_rd_data[TIME_W+WORD_W-1:TIME_W];
   // The one bounds comparator that every scanned entry goes through.
   assign in_range = (lo_ff <= rd_time) && (rd_time <= hi_ff);

   tsarq_ram #(
      .WIDTH(TIME_W + WORD_W),
      .DEPTH(CAPACITY),
      .ADDR_W(AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(fill_ff[AW-1:0]),
      .wr_data({req_word, req_time}),
      .rd_en  (ram_rd_en),
      .rd_addr(scan_ff[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      first_in      = first_ff;
      newest_in     = newest_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pend_valid_in = pend_valid_ff;
      pend_time_in  = pend_time_ff;
      pend_word_in  = pend_word_ff;
      pend_count_in = pend_count_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_found_in  = out_found_ff;
      out_time_in   = out_time_ff;
      out_word_in   = out_word_ff;
      out_last_in   = out_last_ff;
      out_count_in  = out_count_ff;
      out_stored_in = out_stored_ff;
      out_first_in  = out_first_ff;
      out_newest_in = out_newest_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      // Statistics seen by query results; the store does not change during a scan.
      if (state_ff != S_IDLE) begin
         out_stored_in = fill_ff;
         out_first_in  = (fill_ff != '0) ? first_ff : '0;
         out_newest_in = (fill_ff != '0) ? newest_ff : '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0] == ACT_APPEND) begin
                  if ((fill_ff != '0) && (req_time <= newest_ff)) begin
                     out_status_in = STATUS_NOT_NEWER;
                  end else if (fill_ff == CW'(CAPACITY)) begin
                     out_status_in = STATUS_FULL;
                  end else begin
                     out_status_in = STATUS_APPENDED;
                     ram_wr_en     = 1'b1;
                     fill_in       = fill_ff + CW'(1);
                     newest_in     = req_time;
                     if (fill_ff == '0) begin
                        first_in = req_time;
                     end
                  end
                  out_valid_in  = 1'b1;
                  out_found_in  = 1'b0;
                  out_time_in   = '0;
                  out_word_in   = '0;
                  out_last_in   = 1'b1;
                  out_count_in  = '0;
                  out_stored_in = fill_in;
                  out_first_in  = (fill_in != '0) ? first_in : '0;
                  out_newest_in = (fill_in != '0) ? newest_in : '0;
               end else begin
                  lo_in         = req_lo;
                  hi_in         = req_hi;
                  scan_in       = '0;
                  pend_valid_in = 1'b0;
                  pend_count_in = '0;
                  state_in      = (fill_ff == '0) ? S_DONE : S_READ;
               end
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            // A new match displaces the held one, which then is known not to be last.
            if (!(in_range && pend_valid_ff && !out_free)) begin
               if (in_range) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_status_in = STATUS_QUERY;
                     out_found_in  = 1'b1;
                     out_time_in   = pend_time_ff;
                     out_word_in   = pend_word_ff;
                     out_last_in   = 1'b0;
                     out_count_in  = pend_count_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_time_in  = rd_time;
                  pend_word_in  = rd_word;
                  pend_count_in = pend_count_ff + CW'(1);
               end
               scan_in  = scan_ff + CW'(1);
               state_in = (scan_in == fill_ff) ? S_DONE : S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = STATUS_QUERY;
               out_found_in  = pend_valid_ff;
               out_time_in   = pend_valid_ff ? pend_time_ff : '0;
               out_word_in   = pend_valid_ff ? pend_word_ff : '0;
               out_last_in   = 1'b1;
               out_count_in  = pend_valid_ff ? pend_count_ff : '0;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         pend_count_ff <= pend_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      newest_ff     <= newest_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pend_time_ff  <= pend_time_in;
      pend_word_ff  <= pend_word_in;
      out_status_ff <= out_status_in;
      out_found_ff  <= out_found_in;
      out_time_ff   <= out_time_in;
      out_word_ff   <= out_word_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
      out_stored_ff <= out_stored_in;
      out_first_ff  <= out_first_in;
      out_newest_ff <= out_newest_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_found_ff, out_status_ff};
   assign rsp_tdata  = {
      {(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
      out_newest_ff,
      out_first_ff,
      COUNT_W'(out_stored_ff),
      COUNT_W'(out_count_ff),
      out_word_ff,
      out_time_ff
   };

`ifndef ASSERT_OFF

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("store fill count exceeds capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CMP) |-> (scan_ff < fill_ff))
      else $error("scan index ran past the stored entries");

   a_append_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != STATUS_QUERY) |-> (out_last_ff && !out_found_ff))
      else $error("append status transaction not marked last");

   a_fill_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(fill_ff))
      else $error("store changed during a query scan");

`endif

endmodule

/* rtl/tsarq_ram.sv */
`timescale 1ns / 1ps

module tsarq_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/time_series_append_range_query_checker.sv */
`timescale 1ns / 1ps

module time_series_append_range_query_checker
   #(
   parameter int CAPACITY = tsarq_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [tsarq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [tsarq_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [tsarq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic [tsarq_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 mismatch_count,
   output int                                 pending_count
);

   import tsarq_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic               found;
      stamp_type          entry_time;
      word_type           entry_word;
      logic               last;
      logic [COUNT_W-1:0] match_total;
      logic [COUNT_W-1:0] held;
      stamp_type          oldest;
      stamp_type          newest;
   } store_result_type;

   store_result_type awaited_results[$];
   stamp_type        stamp_copy[CAPACITY];
   word_type         word_copy[CAPACITY];
   int               held_entries;
   stamp_type        newest_held;
   int               errors = 0;

   // Statistics are taken after the request has been applied to the store.
   function automatic store_result_type shape_result(input logic [1:0] status,
                                                     input logic found,
                                                     input stamp_type etime,
                                                     input word_type eword,
                                                     input logic last,
                                                     input int match_total);
      store_result_type r;
      r.status = status;
      r.found = found;
      r.entry_time = etime;
      r.entry_word = eword;
      r.last = last;
      r.match_total = COUNT_W'(match_total);
      r.held = COUNT_W'(held_entries);
      r.oldest = (held_entries != 0) ? stamp_copy[0] : '0;
      r.newest = (held_entries != 0) ? newest_held : '0;
      return r;
   endfunction

   task automatic predict_store_results(input logic act, input stamp_type point_time,
                                        input word_type point_word, input stamp_type lo,
                                        input stamp_type hi);
      logic [1:0]       status;
      int               match_total;
      int               i;
      store_result_type held_back;
      bit               have_one;
      if (act == ACT_APPEND) begin
         // Newness is checked before fullness.
         if (held_entries > 0 && point_time <= newest_held) begin
            status = STATUS_NOT_NEWER;
         end else if (held_entries >= CAPACITY) begin
            status = STATUS_FULL;
         end else begin
            stamp_copy[held_entries] = point_time;
            word_copy[held_entries] = point_word;
            newest_held = point_time;
            held_entries++;
            status = STATUS_APPENDED;
         end
         awaited_results.push_back(shape_result(status, 1'b0, '0, '0, 1'b1, 0));
      end else begin
         match_total = 0;
         have_one = 0;
         for (i = 0; i < held_entries; i++) begin
            if (stamp_copy[i] >= lo && stamp_copy[i] <= hi) begin
               match_total++;
               if (have_one) awaited_results.push_back(held_back);
               held_back = shape_result(STATUS_QUERY, 1'b1, stamp_copy[i], word_copy[i],
                                        1'b0, match_total);
               have_one = 1;
            end
         end
         if (have_one) begin
            held_back.last = 1'b1;
            awaited_results.push_back(held_back);
         end else begin
            awaited_results.push_back(shape_result(STATUS_QUERY, 1'b0, '0, '0, 1'b1, 0));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      store_result_type want;
      if (awaited_results.size() == 0) begin
         $error("result transaction with no request waiting for it: tuser %h tdata %h",
                rsp_tuser, rsp_tdata);
         errors++;
      end else begin
         want = awaited_results.pop_front();
         check_field("status", 64'(want.status), 64'(rsp_tuser[1:0]));
         check_field("entry_found", 64'(want.found), 64'(rsp_tuser[2]));
         check_field("entry_time", want.entry_time, rsp_tdata[63:0]);
         check_field("entry_word", want.entry_word, rsp_tdata[127:64]);
         check_field("last_of_run", 64'(want.last), 64'(rsp_tlast));
         check_field("match_count", 64'(want.match_total), 64'(rsp_tdata[134:128]));
         check_field("stored_count", 64'(want.held), 64'(rsp_tdata[141:135]));
         check_field("first_time", want.oldest, rsp_tdata[205:142]);
         check_field("newest_time", want.newest, rsp_tdata[269:206]);
      end
   endtask

   // The result side is checked first so that a request taken on the same edge
   // cannot stand in for an older one.
   always @(posedge clock) begin
      if (reset) begin
         awaited_results.delete();
         held_entries = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) begin
            predict_store_results(req_tuser[0], req_tdata[63:0], req_tdata[127:64],
                                  req_tdata[191:128], req_tdata[255:192]);
         end
      end
      mismatch_count <= errors;
      pending_count <= awaited_results.size();
   end

endmodule

/* test/time_series_append_range_query_tb.sv */
`timescale 1ns / 1ps

module time_series_append_range_query_tb;

   import tsarq_pkg::*;

   localparam int        CAPACITY  = CAPACITY_DEFAULT;
   localparam stamp_type STAMP_MIN = 64'h8000_0000_0000_0000;
   localparam stamp_type STAMP_MAX = 64'h7fff_ffff_ffff_ffff;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // point_time, point_word, range_start, range_end, from bit 0 up
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // action
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // entry_time, entry_word, match_count, stored_count, first_time, newest_time, zeros
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status, entry_found
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   int mismatches;
   int pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Timestamps the store has taken, kept only to aim appends and queries.
   stamp_type appended_stamps[$];
   stamp_type newest_stamp;

   time_series_append_range_query #(.CAPACITY(CAPACITY)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   time_series_append_range_query_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .mismatch_count(mismatches),
      .pending_count(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(input logic act, input stamp_type point_time,
                               input word_type point_word, input stamp_type lo,
                               input stamp_type hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {hi, lo, point_word, point_time};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_append(input stamp_type point_time, input word_type point_word);
      send_request(ACT_APPEND, point_time, point_word, rand64(), rand64());
      if (appended_stamps.size() < CAPACITY &&
          (appended_stamps.size() == 0 || point_time > newest_stamp)) begin
         appended_stamps.push_back(point_time);
         newest_stamp = point_time;
      end
   endtask

   task automatic send_query(input stamp_type lo, input stamp_type hi);
      send_request(ACT_QUERY, rand64(), rand64(), lo, hi);
   endtask

   // The store never shrinks, so newer appends are rationed to fill it in
   // about the length of the random part; bounds are mostly placed on or
   // right beside stored timestamps.
   task automatic random_item();
      stamp_type t;
      stamp_type lo;
      stamp_type hi;
      int        i;
      int        j;
      int        swap;
      if ($urandom_range(99) < 35) begin
         if ($urandom_range(99) < 55) begin
            if ($urandom_range(1)) t = newest_stamp + $urandom_range(1, 4);
            else t = newest_stamp + 1 + (rand64() >> 9);
         end else begin
            t = rand64();
            if (t > newest_stamp) t = newest_stamp - $urandom_range(0, 3);
            if (t > newest_stamp) t = newest_stamp;
         end
         send_append(t, rand64());
      end else begin
         i = $urandom_range(appended_stamps.size() - 1);
         j = $urandom_range(appended_stamps.size() - 1);
         if (i > j) begin
            swap = i;
            i = j;
            j = swap;
         end
         case ($urandom_range(9))
            0: begin
               lo = STAMP_MIN;
               hi = STAMP_MAX;
            end
            1, 2: begin
               lo = rand64();
               hi = rand64();
            end
            3: begin
               lo = appended_stamps[j] + 1;
               hi = appended_stamps[i];
            end
            default: begin
               lo = $urandom_range(1) ? appended_stamps[i] : appended_stamps[i] + 1;
               hi = $urandom_range(1) ? appended_stamps[j] : appended_stamps[j] - 1;
            end
         endcase
         send_query(lo, hi);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_query(STAMP_MIN, STAMP_MAX);
      send_append(STAMP_MIN, 64'hffff_ffff_ffff_ffff);
      send_append(STAMP_MIN, 64'h0);
      send_query(STAMP_MIN, STAMP_MIN);
      send_append(-64'sd5, 64'h0);
      send_append(-64'sd6, rand64());
      send_append(64'sd0, 64'h0123_4567_89ab_cdef);
      send_query(STAMP_MIN, STAMP_MAX);
      send_query(64'sd5, -64'sd5);
      send_query(-64'sd5, -64'sd5);
      send_query(-64'sd4, -64'sd1);
      send_query(-64'sd5, 64'sd0);
      send_query(64'sd1, STAMP_MAX);
      send_query(STAMP_MIN + 1, -64'sd1);

      repeat (118) random_item();
      send_idle_pct = 75;
      repeat (118) random_item();
      send_idle_pct = 0;
      rsp_stall_pct <= 75;
      repeat (118) random_item();
      send_idle_pct = 31;
      rsp_stall_pct <= 31;
      repeat (118) random_item();

      // Make sure the full store is reached, then hit it both ways.
      while (appended_stamps.size() < CAPACITY) send_append(newest_stamp + 1, rand64());
      send_append(STAMP_MAX, rand64());
      send_append(newest_stamp, rand64());
      send_query(STAMP_MIN, STAMP_MAX);
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * CAPACITY + 20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
